// File: hdl/psrf_pkg.sv
// shared types and constants for the per-sender replay filter
`default_nettype none

package psrf_pkg;

  localparam int unsigned TABLE_ENTRIES = 8;
  localparam int unsigned SID_W         = 32;
  localparam int unsigned CNT_W         = 16;
  localparam int unsigned IN_DATA_W     = 48;
  localparam int unsigned OUT_DATA_W    = 8;

  typedef enum logic [1:0] {
    OUT_NEWER  = 2'd0,
    OUT_STALE  = 2'd1,
    OUT_STORED = 2'd2,
    OUT_FULL   = 2'd3
  } outcome_e;

  typedef struct packed {
    logic             vld;
    logic             done;
    logic [SID_W-1:0] sid;
    logic [CNT_W-1:0] cnt;
    logic             accept;
    outcome_e         outcome;
  } tok_t;

endpackage

`default_nettype wire

// File: hdl/psrf_cell.sv
// one table entry: sender, last counter and valid mark, passing the lookup beat along
`default_nettype none

module psrf_cell
  import psrf_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic adv_i,
  input  wire tok_t tok_i,
  output tok_t      tok_o
);

  logic             valid_q, valid_d;
  logic [SID_W-1:0] sender_q, sender_d;
  logic [CNT_W-1:0] last_q, last_d;
  logic             tok_vld_q;
  tok_t             tok_q, tok_d;
  logic [CNT_W-1:0] diff;
  logic             newer;

  assign diff  = tok_i.cnt - last_q;
  assign newer = (diff != '0) && !diff[CNT_W-1];

  always_comb begin
    valid_d  = valid_q;
    sender_d = sender_q;
    last_d   = last_q;
    tok_d    = tok_i;
    if (tok_i.vld && !tok_i.done) begin
      if (valid_q && (sender_q == tok_i.sid)) begin
        tok_d.done    = 1'b1;
        tok_d.accept  = newer;
        tok_d.outcome = newer ? OUT_NEWER : OUT_STALE;
        if (newer) begin
          last_d = tok_i.cnt;
        end
      end else if (!valid_q) begin
        // valid entries form a prefix, so no later entry can match
        valid_d       = 1'b1;
        sender_d      = tok_i.sid;
        last_d        = tok_i.cnt;
        tok_d.done    = 1'b1;
        tok_d.accept  = 1'b1;
        tok_d.outcome = OUT_STORED;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      tok_vld_q <= 1'b0;
    end else if (adv_i) begin
      valid_q   <= valid_d;
      tok_vld_q <= tok_d.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sender_q <= sender_d;
      last_q   <= last_d;
      tok_q    <= tok_d;
    end
  end

  always_comb begin
    tok_o     = tok_q;
    tok_o.vld = tok_vld_q;
  end

endmodule

`default_nettype wire

// File: hdl/per_sender_replay_filter.sv
// per-sender replay filter: a chain of table cells that a lookup beat walks through
// the beat passes the input register and then every cell register before the result is registered
// one packet at a time: the next input beat is taken only once the last one leaves the cell chain
// a result waiting at the output does not block the next input beat
// reset clears all valid marks and the in-flight beat; no clearing pass is needed
`default_nettype none

module per_sender_replay_filter
  import psrf_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // sender_id[31:0], sequence_count[47:32]
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata   // accept[0], outcome[2:1], zero[7:3]
);

  tok_t     tok [0:TABLE_ENTRIES];
  tok_t     tok_in;
  tok_t     in_tok_q;
  logic     in_vld_q;
  logic     busy_q;
  logic     out_vld_q;
  logic     out_accept_q;
  outcome_e out_outcome_q;
  logic     adv;
  logic     s_fire;
  logic     last_fire;

  assign s_axis_tready = !busy_q;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign adv           = !tok[TABLE_ENTRIES].vld || !out_vld_q || m_axis_tready;
  assign last_fire     = tok[TABLE_ENTRIES].vld && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      busy_q   <= 1'b0;
    end else begin
      if (s_fire) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (s_fire) begin
        busy_q <= 1'b1;
      end else if (last_fire) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_tok_q.vld     <= 1'b1;
      in_tok_q.done    <= 1'b0;
      in_tok_q.sid     <= s_axis_tdata[SID_W-1:0];
      in_tok_q.cnt     <= s_axis_tdata[SID_W+CNT_W-1:SID_W];
      in_tok_q.accept  <= 1'b1;
      in_tok_q.outcome <= OUT_FULL;
    end
  end

  always_comb begin
    tok_in     = in_tok_q;
    tok_in.vld = in_vld_q;
  end

  assign tok[0] = tok_in;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    psrf_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .adv_i (adv),
      .tok_i (tok[g]),
      .tok_o (tok[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (last_fire) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (last_fire) begin
      out_accept_q  <= tok[TABLE_ENTRIES].accept;
      out_outcome_q <= tok[TABLE_ENTRIES].outcome;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OUT_DATA_W-3){1'b0}}, out_outcome_q, out_accept_q};

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// testbench for the per-sender replay filter: directed table then random packets vs predictor
`timescale 1ns / 1ps

module tb_top;
  import psrf_pkg::*;

  typedef struct packed {
    logic     accept;
    outcome_e outcome;
  } verdict_t;

  typedef struct packed {
    logic [SID_W-1:0] sid;
    logic [CNT_W-1:0] cnt;
    logic             typed;
    verdict_t         want;
  } stim_row_t;

  localparam int unsigned DIRECTED_ROWS = 20;
  localparam int unsigned POOL_SIZE     = 12;
  localparam int unsigned RANDOM_ITEMS  = 1130;
  localparam int unsigned LATENCY       = TABLE_ENTRIES + 2;
  localparam int unsigned MAX_REPORTS   = 10;

  localparam verdict_t V_NONE   = '{1'b0, OUT_NEWER};
  localparam verdict_t V_NEWER  = '{1'b1, OUT_NEWER};
  localparam verdict_t V_STALE  = '{1'b0, OUT_STALE};
  localparam verdict_t V_STORED = '{1'b1, OUT_STORED};

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // sender_id[31:0], sequence_count[47:32]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // accept[0], outcome[2:1], zero[7:3]

  per_sender_replay_filter u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  verdict_t         verdict_q [$];
  int unsigned      fail_count = 0;
  bit               no_idle    = 1'b0;
  bit               entry_used [TABLE_ENTRIES];
  logic [SID_W-1:0] entry_sid  [TABLE_ENTRIES];
  logic [CNT_W-1:0] entry_cnt  [TABLE_ENTRIES];

  function automatic verdict_t filter_packet(input logic [SID_W-1:0] sid,
                                             input logic [CNT_W-1:0] cnt);
    int              hit;
    int              free_idx;
    logic [CNT_W-1:0] diff;
    verdict_t        v;
    hit       = -1;
    free_idx  = -1;
    v.accept  = 1'b1;
    v.outcome = OUT_FULL;
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      if (entry_used[k]) begin
        if (hit < 0 && entry_sid[k] == sid) hit = k;
      end else if (free_idx < 0) begin
        free_idx = k;
      end
    end
    if (hit >= 0) begin
      diff = cnt - entry_cnt[hit];
      if (diff != '0 && !diff[CNT_W-1]) begin
        entry_cnt[hit] = cnt;
        v.outcome      = OUT_NEWER;
      end else begin
        v.accept  = 1'b0;
        v.outcome = OUT_STALE;
      end
    end else if (free_idx >= 0) begin
      entry_used[free_idx] = 1'b1;
      entry_sid[free_idx]  = sid;
      entry_cnt[free_idx]  = cnt;
      v.outcome            = OUT_STORED;
    end
    return v;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_packet(input logic [SID_W-1:0] sid, input logic [CNT_W-1:0] cnt,
                             input logic typed, input verdict_t want);
    int unsigned gap;
    verdict_t    v;
    gap = no_idle ? 0 : pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {cnt, sid};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    v = filter_packet(sid, cnt);
    verdict_q.push_back(typed ? want : v);
  endtask

  task automatic wait_until_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (verdict_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned stall_left;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (no_idle || stall_left == 0) begin
        m_axis_tready <= 1'b1;
        if (!no_idle && $urandom_range(0, 4) == 0) stall_left = pick_gap();
      end else begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end
    end
  end

  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (verdict_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected result beat: accept %0b outcome %0d",
                   m_axis_tdata[0], m_axis_tdata[2:1]);
      end else begin
        want = verdict_q.pop_front();
        if (m_axis_tdata[0] !== want.accept || m_axis_tdata[2:1] !== want.outcome) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("mismatch: expected accept %0b outcome %0d, got accept %0b outcome %0d",
                     want.accept, want.outcome, m_axis_tdata[0], m_axis_tdata[2:1]);
        end
      end
    end
  end

  initial begin
    stim_row_t        rows [DIRECTED_ROWS];
    logic [SID_W-1:0] sender_pool [POOL_SIZE];
    logic [SID_W-1:0] sid;
    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] base;
    rows = '{
      '{32'h0000_0000, 16'h0000, 1'b1, V_STORED},
      '{32'h0000_0000, 16'h0000, 1'b1, V_STALE},
      '{32'h0000_0000, 16'h8000, 1'b1, V_STALE},
      '{32'h0000_0000, 16'h7FFF, 1'b1, V_NEWER},
      '{32'h0000_0000, 16'hFFFF, 1'b1, V_STALE},
      '{32'h0000_0000, 16'h0000, 1'b0, V_NONE},
      '{32'h0000_0000, 16'hFFFE, 1'b0, V_NONE},
      '{32'h0000_0000, 16'h0003, 1'b0, V_NONE},
      '{32'h0000_0000, 16'h0002, 1'b0, V_NONE},
      '{32'hFFFF_FFFF, 16'hFFFF, 1'b1, V_STORED},
      '{32'hFFFF_FFFF, 16'h0000, 1'b0, V_NONE},
      '{32'hFFFF_FFFF, 16'h7FFF, 1'b0, V_NONE},
      '{32'hFFFF_FFFF, 16'h7FFF, 1'b1, V_STALE},
      '{32'hA5A5_A5A5, 16'h5A5A, 1'b1, V_STORED},
      '{32'h5A5A_5A5A, 16'hA5A5, 1'b1, V_STORED},
      '{32'hA5A5_A5A5, 16'hDADA, 1'b0, V_NONE},
      '{32'h5A5A_5A5A, 16'h25A5, 1'b1, V_STALE},
      '{32'h0000_0000, 16'h0004, 1'b0, V_NONE},
      '{32'h0000_0001, 16'h0001, 1'b1, V_STORED},
      '{32'h8000_0000, 16'h8000, 1'b1, V_STORED}
    };
    sender_pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 32'h5A5A_5A5A,
                    32'h0000_0001, 32'h8000_0000, '0, '0, '0, '0, '0, '0};
    for (int i = 6; i < POOL_SIZE; i++) sender_pool[i] = $urandom;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_packet(rows[i].sid, rows[i].cnt, rows[i].typed, rows[i].want);
    wait_until_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) no_idle <= ($urandom_range(0, 3) == 0);
      if (n == RANDOM_ITEMS / 2) wait_until_drained();
      if ($urandom_range(0, 99) < 85) begin
        sid  = sender_pool[$urandom_range(0, POOL_SIZE - 1)];
        base = 16'($urandom);
        for (int k = 0; k < TABLE_ENTRIES; k++)
          if (entry_used[k] && entry_sid[k] == sid) base = entry_cnt[k];
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: cnt = base + 16'($urandom_range(1, 64));
          5:             cnt = base + 16'($urandom_range(1, 32767));
          6:             cnt = base;
          7:             cnt = base - 16'($urandom_range(1, 64));
          8:             cnt = base + 16'h8000;
          default:       cnt = 16'($urandom);
        endcase
      end else begin
        sid = $urandom;
        cnt = 16'($urandom);
      end
      send_packet(sid, cnt, 1'b0, V_NONE);
    end
    s_axis_tvalid <= 1'b0;

    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (4 * LATENCY) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
